@@ sv/gmp_pkg.sv @@
`default_nettype none

package gmp_pkg;

    localparam int DEF_MAX_VERTS = 64;
    localparam int DEF_MAX_PRIMS = 126;

    localparam int CORNER_W  = 32;
    localparam int KIND_W    = 2;
    localparam int LOCAL_W   = 6;
    localparam int TOTAL_W   = 7;
    localparam int OFFSET_W  = 32;
    localparam int CFG_W     = 7;
    localparam int S_TDATA_W = 3 * CORNER_W;
    localparam int M_TDATA_W = CORNER_W + 3 * LOCAL_W + 2 * OFFSET_W + 2 * TOTAL_W;

    localparam logic [KIND_W-1:0] KIND_PRIM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DESC   = 2'd2;

    localparam logic CFG_VERTEX_LIMIT = 1'b0;
    localparam logic CFG_PRIM_LIMIT   = 1'b1;

    localparam logic [CFG_W-1:0] VLIM_RESET = 7'd64;
    localparam logic [CFG_W-1:0] PLIM_RESET = 7'd126;
    localparam int VLIM_MIN = 3;
    localparam int PLIM_MIN = 1;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef struct packed {
        logic       load;
        logic       compare;
        logic       decide;
        logic       flush;
        logic       add;
        logic [1:0] add_sel;
        logic       emit_prim;
        logic       emit_final;
    } cmd_t;

    typedef struct packed {
        logic       flush_needed;
        logic [2:0] corner_new;
        logic       out_free;
        logic       mesh_end;
    } status_t;

endpackage

`default_nettype wire

@@ sv/gmp_cam.sv @@
`default_nettype none

module gmp_cam #(
    parameter int DEPTH = gmp_pkg::DEF_MAX_VERTS,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                                aclk,
    input  wire logic                                wr_en,
    input  wire logic [IW-1:0]                       wr_addr,
    input  wire logic [gmp_pkg::CORNER_W-1:0]        wr_data,
    input  wire logic [CW-1:0]                       fill,
    input  wire logic                                cmp_en,
    input  wire logic [2:0][gmp_pkg::CORNER_W-1:0]   key,
    output logic      [2:0][DEPTH-1:0]               hit
);
    import gmp_pkg::*;

    logic [CORNER_W-1:0] entry_reg [DEPTH];
    logic [2:0][DEPTH-1:0] hit_reg;
    logic [2:0][DEPTH-1:0] hit_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    // Only entries below the fill level take part in a match.
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < DEPTH; k++) begin
                hit_next[p][k] = (CW'(k) < fill) && (entry_reg[k] == key[p]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

@@ sv/gmp_datapath.sv @@
`default_nettype none

module gmp_datapath #(
    parameter int MAX_VERTS = gmp_pkg::DEF_MAX_VERTS,
    parameter int MAX_PRIMS = gmp_pkg::DEF_MAX_PRIMS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire gmp_pkg::cmd_t                   cmd,
    output gmp_pkg::status_t                     status,
    input  wire logic [gmp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_addr,
    input  wire logic [gmp_pkg::CFG_W-1:0]       cfg_wdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [gmp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [gmp_pkg::KIND_W-1:0]      m_tuser,
    output logic                                 m_tlast
);
    import gmp_pkg::*;

    localparam int IW  = $clog2(MAX_VERTS);
    localparam int CW  = $clog2(MAX_VERTS + 1);
    localparam int PW  = $clog2(MAX_PRIMS + 1);
    localparam int VLW = (CW > CFG_W) ? CW : CFG_W;
    localparam int PLW = (PW > CFG_W) ? PW : CFG_W;

    logic [2:0][CORNER_W-1:0] corner_reg;
    logic                     mesh_end_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [PW-1:0]            prim_reg, prim_next;
    logic [OFFSET_W-1:0]      vbase_reg, vbase_next;
    logic [OFFSET_W-1:0]      pbase_reg, pbase_next;
    logic [CFG_W-1:0]         vlim_cfg_reg, plim_cfg_reg;
    logic                     flush_reg;
    logic [2:0]               new_reg;
    logic                     dup_ba_reg, dup_ca_reg, dup_cb_reg;
    logic [2:0][IW-1:0]       enc_reg, enc;
    logic [2:0][IW-1:0]       local_reg;
    logic [2:0][MAX_VERTS-1:0] hit;
    logic [2:0]               found;

    logic                     out_valid_reg;
    logic [KIND_W-1:0]        out_kind_reg, out_kind_next;
    logic                     out_last_reg, out_last_next;
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;

    logic [VLW-1:0]           vlim_wide, vlim_eff;
    logic [PLW-1:0]           plim_wide, plim_eff;
    logic [VLW:0]             vsum;
    logic [PLW:0]             psum;
    logic [1:0]               fresh;
    logic                     flush_c;
    logic [2:0]               new_c;
    logic                     dup_ba, dup_ca, dup_cb;

    logic [CORNER_W-1:0]      add_corner;
    logic                     add_new;
    logic [IW-1:0]            add_old;
    logic [IW-1:0]            add_local;
    logic                     emit;

    logic [CW+TOTAL_W-1:0]    count_ext;
    logic [PW+TOTAL_W-1:0]    prim_ext;
    logic [2:0][IW+LOCAL_W-1:0] local_ext;

    gmp_cam #(
        .DEPTH(MAX_VERTS)
    ) u_cam (
        .aclk   (aclk),
        .wr_en  (cmd.add && add_new),
        .wr_addr(count_reg[IW-1:0]),
        .wr_data(add_corner),
        .fill   (count_reg),
        .cmp_en (cmd.compare),
        .key    (corner_reg),
        .hit    (hit)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            corner_reg   <= s_tdata;
            mesh_end_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlim_cfg_reg <= VLIM_RESET;
            plim_cfg_reg <= PLIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_VERTEX_LIMIT: vlim_cfg_reg <= cfg_wdata;
                CFG_PRIM_LIMIT:   plim_cfg_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        vlim_wide = VLW'(vlim_cfg_reg);
        if (vlim_wide < VLW'(VLIM_MIN)) begin
            vlim_eff = VLW'(VLIM_MIN);
        end else if (vlim_wide > VLW'(MAX_VERTS)) begin
            vlim_eff = VLW'(MAX_VERTS);
        end else begin
            vlim_eff = vlim_wide;
        end
        plim_wide = PLW'(plim_cfg_reg);
        if (plim_wide < PLW'(PLIM_MIN)) begin
            plim_eff = PLW'(PLIM_MIN);
        end else if (plim_wide > PLW'(MAX_PRIMS)) begin
            plim_eff = PLW'(MAX_PRIMS);
        end else begin
            plim_eff = plim_wide;
        end
    end

    // The list never holds a value twice, so at most one hit per corner.
    always_comb begin
        for (int p = 0; p < 3; p++) begin
            found[p] = |hit[p];
            enc[p]   = '0;
            for (int k = 0; k < MAX_VERTS; k++) begin
                if (hit[p][k]) begin
                    enc[p] = enc[p] | IW'(k);
                end
            end
        end
    end

    always_comb begin
        fresh    = {1'b0, !found[0]} + {1'b0, !found[1]} + {1'b0, !found[2]};
        vsum     = (VLW + 1)'(count_reg) + (VLW + 1)'(fresh);
        psum     = (PLW + 1)'(prim_reg) + (PLW + 1)'(1);
        flush_c  = ((vsum > (VLW + 1)'(vlim_eff)) || (psum > (PLW + 1)'(plim_eff)))
                   && (prim_reg != '0);
        dup_ba   = (corner_reg[1] == corner_reg[0]);
        dup_ca   = (corner_reg[2] == corner_reg[0]);
        dup_cb   = (corner_reg[2] == corner_reg[1]);
        new_c[0] = !(found[0] && !flush_c);
        new_c[1] = !(found[1] && !flush_c) && !dup_ba;
        new_c[2] = !(found[2] && !flush_c) && !dup_ca && !dup_cb;
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            flush_reg  <= flush_c;
            new_reg    <= new_c;
            dup_ba_reg <= dup_ba;
            dup_ca_reg <= dup_ca;
            dup_cb_reg <= dup_cb;
            enc_reg    <= enc;
        end
    end

    // A repeated corner takes the local index of its earlier twin.
    always_comb begin
        unique case (cmd.add_sel)
            SEL_A: begin
                add_corner = corner_reg[0];
                add_new    = new_reg[0];
                add_old    = enc_reg[0];
            end
            SEL_B: begin
                add_corner = corner_reg[1];
                add_new    = new_reg[1];
                add_old    = dup_ba_reg ? local_reg[0] : enc_reg[1];
            end
            SEL_C: begin
                add_corner = corner_reg[2];
                add_new    = new_reg[2];
                add_old    = dup_ca_reg ? local_reg[0]
                           : (dup_cb_reg ? local_reg[1] : enc_reg[2]);
            end
            default: begin
                add_corner = '0;
                add_new    = 1'b0;
                add_old    = '0;
            end
        endcase
        add_local = add_new ? count_reg[IW-1:0] : add_old;
    end

    always_ff @(posedge aclk) begin
        if (cmd.add) begin
            unique case (cmd.add_sel)
                SEL_A:   local_reg[0] <= add_local;
                SEL_B:   local_reg[1] <= add_local;
                SEL_C:   local_reg[2] <= add_local;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        prim_next  = prim_reg;
        vbase_next = vbase_reg;
        pbase_next = pbase_reg;
        if (cmd.flush) begin
            vbase_next = vbase_reg + OFFSET_W'(count_reg);
            pbase_next = pbase_reg + OFFSET_W'(prim_reg);
            count_next = '0;
            prim_next  = '0;
        end
        if (cmd.add && add_new) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.emit_prim) begin
            prim_next = prim_reg + PW'(1);
        end
        if (cmd.emit_final) begin
            vbase_next = '0;
            pbase_next = '0;
            count_next = '0;
            prim_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            prim_reg  <= '0;
            vbase_reg <= '0;
            pbase_reg <= '0;
        end else begin
            count_reg <= count_next;
            prim_reg  <= prim_next;
            vbase_reg <= vbase_next;
            pbase_reg <= pbase_next;
        end
    end

    always_comb begin
        count_ext = {{TOTAL_W{1'b0}}, count_reg};
        prim_ext  = {{TOTAL_W{1'b0}}, prim_reg};
        for (int p = 0; p < 3; p++) begin
            local_ext[p] = {{LOCAL_W{1'b0}}, local_reg[p]};
        end
    end

    always_comb begin
        emit          = cmd.flush || (cmd.add && add_new) || cmd.emit_prim || cmd.emit_final;
        out_kind_next = KIND_PRIM;
        out_last_next = 1'b0;
        out_data_next = '0;
        if (cmd.flush || cmd.emit_final) begin
            out_kind_next = KIND_DESC;
            out_last_next = cmd.emit_final;
            out_data_next = {prim_ext[TOTAL_W-1:0], pbase_reg, count_ext[TOTAL_W-1:0],
                             vbase_reg, {3 * LOCAL_W{1'b0}}, {CORNER_W{1'b0}}};
        end else if (cmd.add) begin
            out_kind_next = KIND_VERTEX;
            out_data_next = {{(M_TDATA_W - CORNER_W){1'b0}}, add_corner};
        end else if (cmd.emit_prim) begin
            out_kind_next = KIND_PRIM;
            out_last_next = !mesh_end_reg;
            out_data_next = {{(2 * TOTAL_W + 2 * OFFSET_W){1'b0}},
                             local_ext[2][LOCAL_W-1:0], local_ext[1][LOCAL_W-1:0],
                             local_ext[0][LOCAL_W-1:0], {CORNER_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign status.flush_needed = flush_reg;
    assign status.corner_new   = new_reg;
    assign status.out_free     = !out_valid_reg || m_tready;
    assign status.mesh_end     = mesh_end_reg;

endmodule

`default_nettype wire

@@ sv/gmp_ctrl.sv @@
`default_nettype none

module gmp_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire gmp_pkg::status_t status,
    output gmp_pkg::cmd_t         cmd
);
    import gmp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CMP   = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_DESC  = 4'd3;
    localparam logic [3:0] ST_ADD_A = 4'd4;
    localparam logic [3:0] ST_ADD_B = 4'd5;
    localparam logic [3:0] ST_ADD_C = 4'd6;
    localparam logic [3:0] ST_PRIM  = 4'd7;
    localparam logic [3:0] ST_FINAL = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_DEC;
            end
            ST_DEC: begin
                cmd.decide = 1'b1;
                state_next = ST_DESC;
            end
            ST_DESC: begin
                if (!status.flush_needed) begin
                    state_next = ST_ADD_A;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_ADD_A;
                end
            end
            ST_ADD_A: begin
                cmd.add_sel = SEL_A;
                if (!status.corner_new[0] || status.out_free) begin
                    cmd.add    = 1'b1;
                    state_next = ST_ADD_B;
                end
            end
            ST_ADD_B: begin
                cmd.add_sel = SEL_B;
                if (!status.corner_new[1] || status.out_free) begin
                    cmd.add    = 1'b1;
                    state_next = ST_ADD_C;
                end
            end
            ST_ADD_C: begin
                cmd.add_sel = SEL_C;
                if (!status.corner_new[2] || status.out_free) begin
                    cmd.add    = 1'b1;
                    state_next = ST_PRIM;
                end
            end
            ST_PRIM: begin
                if (status.out_free) begin
                    cmd.emit_prim = 1'b1;
                    state_next    = status.mesh_end ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/greedy_meshlet_partitioner_core.sv @@
`default_nettype none

// Greedy meshlet builder. Each input beat is one triangle (three global vertex indices,
// tlast marking the last triangle of the mesh); each output beat is one record, with the
// kind on tuser: a new unique vertex, a primitive of three meshlet-local indices, or a
// meshlet descriptor with offsets and counts, and tlast on the last record of a triangle.
// The sequencer takes one triangle at a time: it loads it, compares all three corners
// against the vertex list at once, runs the limit test, and then walks the descriptor
// (when a flush is needed), the three corners and the primitive one step per cycle
// through a single result register, holding a step while the result channel holds a
// record back; a triangle that ends the mesh adds a last descriptor. The vertex list is a row of
// registers and is not cleared at reset; only entries below the fill count are matched.
// The vertex and primitive limits are clamped to 3..MAX_VERTS and 1..MAX_PRIMS.
module greedy_meshlet_partitioner_core #(
    parameter int MAX_VERTS = gmp_pkg::DEF_MAX_VERTS,
    parameter int MAX_PRIMS = gmp_pkg::DEF_MAX_PRIMS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // corner_a, corner_b, corner_c
    input  wire logic [gmp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // global_vertex, local_a, local_b, local_c, vertex_start, vertex_total,
    // primitive_start, primitive_total
    output logic      [gmp_pkg::M_TDATA_W-1:0]   m_tdata,
    // record_kind
    output logic      [gmp_pkg::KIND_W-1:0]      m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_addr,
    input  wire logic [gmp_pkg::CFG_W-1:0]       cfg_wdata
);
    import gmp_pkg::*;

    cmd_t    cmd;
    status_t status;

    gmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    gmp_datapath #(
        .MAX_VERTS(MAX_VERTS),
        .MAX_PRIMS(MAX_PRIMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.compare, cmd.decide, cmd.flush, cmd.add,
                  cmd.emit_prim, cmd.emit_final}))
        else $error("More than one datapath command in a cycle.");

    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush || cmd.emit_prim || cmd.emit_final) |-> status.out_free)
        else $error("Record issued while the result register is occupied.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input taken again right after a triangle was accepted.");

    a_desc_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_DESC)) |-> (m_tdata[M_TDATA_W-1 -: TOTAL_W] != '0))
        else $error("Descriptor issued for an empty meshlet.");
`endif

endmodule

`default_nettype wire
